// ----- sv/anharmonic_chain_time_step_defines.svh -----
// ----------------------------------------------------------------------------
// anharmonic_chain_time_step_defines.svh
// assertion macros shared by the chain time-step rtl
// ----------------------------------------------------------------------------
`ifndef ANHARMONIC_CHAIN_TIME_STEP_DEFINES_SVH
`define ANHARMONIC_CHAIN_TIME_STEP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property checked while out of reset
`define ACTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked on every edge, reset included
`define ACTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ACTS_ASSERT(lbl, prop, msg)
`define ACTS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/acts_pkg.sv -----
// ----------------------------------------------------------------------------
// acts_pkg
// types, codes and saturation helper for the chain time-step block
// ----------------------------------------------------------------------------
`default_nettype none

package acts_pkg;

  localparam int unsigned QW = 32;

  // function codes of an input item
  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_STEP = 2'd1,
    FUNC_READ = 2'd2
  } func_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SPRING = 3'd0,
    REG_REST   = 3'd1,
    REG_QUAD   = 3'd2,
    REG_CUBIC  = 3'd3,
    REG_DT     = 3'd4,
    REG_RING   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [8:0]         site_index;
    logic signed [31:0] load_displacement;
    logic signed [31:0] load_velocity;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] site_displacement;
    logic signed [31:0] site_velocity;
    logic               saturated;
  } out_item_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_OUT,
    ST_DONE,
    ST_A_RD0,
    ST_A_RDL,
    ST_A_RDN,
    ST_A_RDR,
    ST_A_CATCH,
    ST_F_DIFF,
    ST_F_MUL,
    ST_F_CAP,
    ST_F_SUM,
    ST_B_RD,
    ST_B_MV,
    ST_B_CV,
    ST_B_MU,
    ST_B_CU
  } state_t;

  // clip a wide value to 32 bit signed, msb of the result flags a clip
  function automatic logic [32:0] sat_q(input logic signed [63:0] x);
    logic [32:0] r;
    if (x > 64'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (x < -64'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, x[31:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/acts_mul.sv -----
// ----------------------------------------------------------------------------
// acts_mul
// shared signed 32x32 multiplier with registered full-width product
// ----------------------------------------------------------------------------
`default_nettype none

module acts_mul (
  input  wire logic               clk,
  input  wire logic signed [31:0] op_a,
  input  wire logic signed [31:0] op_b,
  output logic signed [63:0]      prod_r
);

  // the product is registered and lands in the cycle after the operands
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

`default_nettype wire

// ----- sv/anharmonic_chain_time_step.sv -----
// ----------------------------------------------------------------------------
// anharmonic_chain_time_step
// periodic alpha-beta chain held in on-chip memories, one symplectic euler
// tick per step command, load and read of single sites
// ----------------------------------------------------------------------------
//  channel   ports                              transfer
//  input     start, busy, in_item               start high while busy low
//  result    out_valid, out_item                one cycle strobe, no stall
//  config    cfg_we, cfg_index, cfg_data        cfg_we high, no wait
//
// load, read and func 3 keep busy only in ST_RD_OUT (read) or ST_DONE, and
// the result strobe is registered from that state.
// a step keeps busy on a ring of n sites and strobes from ST_DONE: priming,
// the wrap bond, then each other bond (five passes through the shared
// multiplier), then the velocity and displacement updates of each site, and
// ST_DONE to finish.
// reset is synchronous and clears control, flag and configuration; the site
// memories hold garbage until loaded. results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module anharmonic_chain_time_step #(
  parameter int SITES     = 512,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire acts_pkg::in_item_t  in_item,
  output logic                     out_valid,
  output acts_pkg::out_item_t      out_item,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);

  import acts_pkg::*;
  `include "anharmonic_chain_time_step_defines.svh"

  localparam int AW = (SITES > 1) ? $clog2(SITES) : 1;

  // configuration registers
  logic signed [31:0] spring_r, rest_r, quad_c_r, cubic_r;
  logic [30:0]        dt_r;
  logic [9:0]         ring_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spring_r <= 32'sd65536;
      rest_r   <= 32'sd65536;
      quad_c_r <= 32'sd65536;
      cubic_r  <= 32'sd0;
      dt_r     <= 31'd412;
      ring_r   <= 10'd401;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPRING: spring_r <= cfg_data;
        REG_REST:   rest_r   <= cfg_data;
        REG_QUAD:   quad_c_r <= cfg_data;
        REG_CUBIC:  cubic_r  <= cfg_data;
        REG_DT:     dt_r     <= cfg_data[30:0];
        REG_RING:   ring_r   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // ring length clamped to 3..SITES, as last index
  logic [31:0]   ring32, n32;
  logic [AW-1:0] nm1;
  always_comb begin
    ring32 = 32'(ring_r);
    if (ring32 < 32'd3) begin
      n32 = 32'd3;
    end else if (ring32 > 32'(SITES)) begin
      n32 = 32'(SITES);
    end else begin
      n32 = ring32;
    end
    nm1 = AW'(n32 - 32'd1);
  end

  // control and datapath registers
  state_t             state_r, state_nxt;
  logic [AW-1:0]      j_r, j_nxt;
  logic [2:0]         k_r, k_nxt;
  logic               pre_r, pre_nxt;
  logic               hit_r, hit_nxt;
  logic               clip_r, clip_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;
  logic signed [31:0] u0_r, u0_nxt, left_r, left_nxt, right_r, right_nxt;
  logic signed [31:0] s_r, s_nxt, lin_r, lin_nxt, sq_r, sq_nxt;
  logic signed [31:0] quad_r, quad_nxt, cube_r, cube_nxt, cub_r, cub_nxt;
  logic signed [31:0] prev_r, prev_nxt, uold_r, uold_nxt, vold_r, vold_nxt;
  logic signed [31:0] vnew_r, vnew_nxt;

  // memories and their ports
  logic signed [31:0] disp_mem [SITES];
  logic signed [31:0] vel_mem  [SITES];
  logic signed [31:0] acc_mem  [SITES];
  logic signed [31:0] disp_q, vel_q, acc_q;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               disp_we, vel_we, acc_we;
  logic signed [31:0] disp_wd, vel_wd, acc_wd;

  always_ff @(posedge clk) begin
    if (disp_we) begin
      disp_mem[wr_addr] <= disp_wd;
    end
    disp_q <= disp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (vel_we) begin
      vel_mem[wr_addr] <= vel_wd;
    end
    vel_q <= vel_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[wr_addr] <= acc_wd;
    end
    acc_q <= acc_mem[rd_addr];
  end

  // shared multiplier
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_r;
  logic signed [63:0] prod_sh;

  acts_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  assign prod_sh = prod_r >>> FRAC_BITS;

  logic in_hit;
  assign in_hit = (32'(in_item.site_index) < 32'(SITES));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_item.func)
            FUNC_STEP: state_nxt = ST_A_RD0;
            FUNC_READ: state_nxt = ST_RD_OUT;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_RD_OUT:  state_nxt = ST_IDLE;
      ST_DONE:    state_nxt = ST_IDLE;
      ST_A_RD0:   state_nxt = ST_A_RDL;
      ST_A_RDL:   state_nxt = ST_A_RDN;
      ST_A_RDN:   state_nxt = ST_F_DIFF;
      ST_A_RDR:   state_nxt = ST_A_CATCH;
      ST_A_CATCH: state_nxt = ST_F_DIFF;
      ST_F_DIFF:  state_nxt = ST_F_MUL;
      ST_F_MUL:   state_nxt = ST_F_CAP;
      ST_F_CAP:   state_nxt = (k_r == 3'd4) ? ST_F_SUM : ST_F_MUL;
      ST_F_SUM: begin
        if (!pre_r && (j_r == nm1)) begin
          state_nxt = ST_B_RD;
        end else begin
          state_nxt = ST_A_RDR;
        end
      end
      ST_B_RD:    state_nxt = ST_B_MV;
      ST_B_MV:    state_nxt = ST_B_CV;
      ST_B_CV:    state_nxt = ST_B_MU;
      ST_B_MU:    state_nxt = ST_B_CU;
      ST_B_CU:    state_nxt = (j_r == nm1) ? ST_DONE : ST_B_RD;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  logic [32:0] sat_a, sat_b;
  always_comb begin
    j_nxt         = j_r;
    k_nxt         = k_r;
    pre_nxt       = pre_r;
    hit_nxt       = hit_r;
    clip_nxt      = clip_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    u0_nxt        = u0_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    s_nxt         = s_r;
    lin_nxt       = lin_r;
    sq_nxt        = sq_r;
    quad_nxt      = quad_r;
    cube_nxt      = cube_r;
    cub_nxt       = cub_r;
    prev_nxt      = prev_r;
    uold_nxt      = uold_r;
    vold_nxt      = vold_r;
    vnew_nxt      = vnew_r;
    rd_addr       = j_r;
    wr_addr       = j_r;
    disp_we       = 1'b0;
    vel_we        = 1'b0;
    acc_we        = 1'b0;
    disp_wd       = in_item.load_displacement;
    vel_wd        = in_item.load_velocity;
    acc_wd        = 32'sd0;
    mul_a         = 32'sd0;
    mul_b         = 32'sd0;
    sat_a         = 33'd0;
    sat_b         = 33'd0;
    case (state_r)
      ST_IDLE: begin
        rd_addr = AW'(in_item.site_index);
        wr_addr = AW'(in_item.site_index);
        hit_nxt = in_hit;
        if (start && (in_item.func == FUNC_LOAD) && in_hit) begin
          disp_we = 1'b1;
          vel_we  = 1'b1;
        end
      end
      ST_RD_OUT: begin
        out_valid_nxt                  = 1'b1;
        out_item_nxt.site_displacement = hit_r ? disp_q : 32'sd0;
        out_item_nxt.site_velocity     = hit_r ? vel_q : 32'sd0;
        out_item_nxt.saturated         = clip_r;
      end
      ST_DONE: begin
        out_valid_nxt                  = 1'b1;
        out_item_nxt.site_displacement = 32'sd0;
        out_item_nxt.site_velocity     = 32'sd0;
        out_item_nxt.saturated         = clip_r;
      end
      // prime the wrap-around bond between the last site and site 0
      ST_A_RD0: begin
        rd_addr = '0;
        pre_nxt = 1'b1;
      end
      ST_A_RDL: begin
        u0_nxt  = disp_q;
        rd_addr = nm1;
      end
      ST_A_RDN: begin
        left_nxt  = disp_q;
        right_nxt = u0_r;
      end
      ST_A_RDR: begin
        rd_addr = (j_r == nm1) ? '0 : j_r + AW'(1);
      end
      ST_A_CATCH: begin
        right_nxt = disp_q;
      end
      // bond stretch offset by rest spacing
      ST_F_DIFF: begin
        sat_a    = sat_q(64'(right_r) - 64'(left_r));
        sat_b    = sat_q(64'(rest_r) - 64'($signed(sat_a[31:0])));
        s_nxt    = sat_b[31:0];
        clip_nxt = clip_r | sat_a[32] | sat_b[32];
        k_nxt    = 3'd0;
      end
      // five products of the pair force, one per pass
      ST_F_MUL: begin
        case (k_r)
          3'd0: begin mul_a = spring_r; mul_b = s_r;    end
          3'd1: begin mul_a = s_r;      mul_b = s_r;    end
          3'd2: begin mul_a = quad_c_r; mul_b = sq_r;   end
          3'd3: begin mul_a = sq_r;     mul_b = s_r;    end
          3'd4: begin mul_a = cubic_r;  mul_b = cube_r; end
          default: ;
        endcase
      end
      ST_F_CAP: begin
        sat_a    = sat_q(prod_sh);
        clip_nxt = clip_r | sat_a[32];
        k_nxt    = k_r + 3'd1;
        case (k_r)
          3'd0:    lin_nxt  = sat_a[31:0];
          3'd1:    sq_nxt   = sat_a[31:0];
          3'd2:    quad_nxt = sat_a[31:0];
          3'd3:    cube_nxt = sat_a[31:0];
          3'd4:    cub_nxt  = sat_a[31:0];
          default: ;
        endcase
      end
      // bond force, then acceleration from left and right bonds
      ST_F_SUM: begin
        sat_a    = sat_q(64'(lin_r) + 64'(quad_r) + 64'(cub_r));
        sat_b    = sat_q(64'(prev_r) - 64'($signed(sat_a[31:0])));
        prev_nxt = sat_a[31:0];
        if (pre_r) begin
          clip_nxt = clip_r | sat_a[32];
          pre_nxt  = 1'b0;
          left_nxt = u0_r;
          j_nxt    = '0;
        end else begin
          clip_nxt = clip_r | sat_a[32] | sat_b[32];
          acc_we   = 1'b1;
          acc_wd   = sat_b[31:0];
          left_nxt = right_r;
          j_nxt    = (j_r == nm1) ? '0 : j_r + AW'(1);
        end
      end
      // velocity then displacement update per site
      ST_B_MV: begin
        uold_nxt = disp_q;
        vold_nxt = vel_q;
        mul_a    = $signed({1'b0, dt_r});
        mul_b    = acc_q;
      end
      ST_B_CV: begin
        sat_a    = sat_q(64'(vold_r) + prod_sh);
        clip_nxt = clip_r | sat_a[32];
        vnew_nxt = sat_a[31:0];
        vel_we   = 1'b1;
        vel_wd   = sat_a[31:0];
      end
      ST_B_MU: begin
        mul_a = $signed({1'b0, dt_r});
        mul_b = vnew_r;
      end
      ST_B_CU: begin
        sat_a    = sat_q(64'(uold_r) + prod_sh);
        clip_nxt = clip_r | sat_a[32];
        disp_we  = 1'b1;
        disp_wd  = sat_a[31:0];
        j_nxt    = j_r + AW'(1);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      j_r         <= '0;
      k_r         <= 3'd0;
      pre_r       <= 1'b0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      pre_r       <= pre_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hit_r      <= hit_nxt;
    out_item_r <= out_item_nxt;
    u0_r       <= u0_nxt;
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    s_r        <= s_nxt;
    lin_r      <= lin_nxt;
    sq_r       <= sq_nxt;
    quad_r     <= quad_nxt;
    cube_r     <= cube_nxt;
    cub_r      <= cub_nxt;
    prev_r     <= prev_nxt;
    uold_r     <= uold_nxt;
    vold_r     <= vold_nxt;
    vnew_r     <= vnew_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // checks
  `ACTS_ASSERT(a_strobe_single, out_valid_r |=> !out_valid_r, "back to back result strobes")
  `ACTS_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted command left block idle")
  `ACTS_ASSERT(a_clip_sticky, clip_r |=> clip_r, "clip flag cleared without reset")
  `ACTS_ASSERT(a_k_range, (state_r == ST_F_CAP) |-> (k_r <= 3'd4), "product index out of range")

endmodule

`default_nettype wire

// ----- tb/anharmonic_chain_time_step_checker.sv -----
// ----------------------------------------------------------------------------
// anharmonic_chain_time_step_checker
// watches the config, command and result channels of the chain block, keeps
// its own copy of the ring and predicts every result, compares field by field
// ----------------------------------------------------------------------------
`default_nettype none

module anharmonic_chain_time_step_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire acts_pkg::in_item_t  in_item,
  input  wire logic                out_valid,
  input  wire acts_pkg::out_item_t out_item,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  output int                       errors,
  output int                       waiting
);

  timeunit 1ns;
  timeprecision 1ps;

  import acts_pkg::*;

  localparam int     RING_MAX = 512;
  localparam longint Q_HI     = 64'sd2147483647;
  localparam longint Q_LO     = -64'sd2147483648;

  // predicted ring contents and settings
  longint    disp_mem [RING_MAX];
  longint    vel_mem  [RING_MAX];
  longint    acc_mem  [RING_MAX];
  logic      clipped;
  longint    k_spring, k_rest, k_quad, k_cubic, k_dt;
  int        ring_cfg;
  out_item_t expected_results [$];

  assign waiting = expected_results.size();

  function automatic longint clip32(longint x);
    if (x > Q_HI) begin
      clipped = 1'b1;
      return Q_HI;
    end
    if (x < Q_LO) begin
      clipped = 1'b1;
      return Q_LO;
    end
    return x;
  endfunction

  // exact product, floor shift, clip
  function automatic longint fx_mul(longint a, longint b);
    return clip32((a * b) >>> 16);
  endfunction

  function automatic longint bond_force(longint right, longint left);
    longint d, s, lin, sq, quad, cube, cub;
    d    = clip32(right - left);
    s    = clip32(k_rest - d);
    lin  = fx_mul(k_spring, s);
    sq   = fx_mul(s, s);
    quad = fx_mul(k_quad, sq);
    cube = fx_mul(sq, s);
    cub  = fx_mul(k_cubic, cube);
    return clip32(lin + quad + cub);
  endfunction

  // one symplectic euler tick over the ring in use
  task automatic advance_ring();
    int n, l, r;
    longint fr, fl, v;
    n = ring_cfg;
    if (n < 3) n = 3;
    if (n > RING_MAX) n = RING_MAX;
    for (int j = 0; j < n; j++) begin
      l = (j == 0) ? n - 1 : j - 1;
      r = (j + 1 == n) ? 0 : j + 1;
      fr = bond_force(disp_mem[r], disp_mem[j]);
      fl = bond_force(disp_mem[j], disp_mem[l]);
      acc_mem[j] = clip32(fl - fr);
    end
    for (int j = 0; j < n; j++) begin
      v = clip32(vel_mem[j] + ((k_dt * acc_mem[j]) >>> 16));
      vel_mem[j] = v;
      disp_mem[j] = clip32(disp_mem[j] + ((k_dt * v) >>> 16));
    end
  endtask

  task automatic report(string what, longint got, longint want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    out_item_t exp_r;
    logic [31:0] rd_u, rd_v;
    if (!rst_n) begin
      k_spring = 65536;
      k_rest   = 65536;
      k_quad   = 65536;
      k_cubic  = 0;
      k_dt     = 412;
      ring_cfg = 401;
      clipped  = 1'b0;
      expected_results.delete();
    end else begin
      // config write
      if (cfg_we) begin
        case (cfg_index)
          REG_SPRING: k_spring = longint'($signed(cfg_data));
          REG_REST:   k_rest   = longint'($signed(cfg_data));
          REG_QUAD:   k_quad   = longint'($signed(cfg_data));
          REG_CUBIC:  k_cubic  = longint'($signed(cfg_data));
          REG_DT:     k_dt     = longint'({33'd0, cfg_data[30:0]});
          REG_RING:   ring_cfg = int'(cfg_data[9:0]);
          default: ;
        endcase
      end
      // result transfer
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("[%0t] mismatch: result with nothing expected", $realtime);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_item.site_displacement !== exp_r.site_displacement)
            report("site_displacement", out_item.site_displacement,
                   exp_r.site_displacement);
          if (out_item.site_velocity !== exp_r.site_velocity)
            report("site_velocity", out_item.site_velocity, exp_r.site_velocity);
          if (out_item.saturated !== exp_r.saturated)
            report("saturated", out_item.saturated, exp_r.saturated);
        end
      end
      // command transfer
      if (start && !busy) begin
        rd_u = '0;
        rd_v = '0;
        case (in_item.func)
          FUNC_LOAD: begin
            disp_mem[in_item.site_index] = longint'(in_item.load_displacement);
            vel_mem[in_item.site_index]  = longint'(in_item.load_velocity);
          end
          FUNC_STEP: advance_ring();
          FUNC_READ: begin
            rd_u = disp_mem[in_item.site_index][31:0];
            rd_v = vel_mem[in_item.site_index][31:0];
          end
          default: ;
        endcase
        exp_r.site_displacement = rd_u;
        exp_r.site_velocity     = rd_v;
        exp_r.saturated         = clipped;
        expected_results.push_back(exp_r);
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/anharmonic_chain_time_step_tb.sv -----
// ----------------------------------------------------------------------------
// anharmonic_chain_time_step_tb
// drives load, step, read and unused commands and config settings into the
// chain block with random sender gaps; the checker predicts and compares
// ----------------------------------------------------------------------------
`default_nettype none

module anharmonic_chain_time_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import acts_pkg::*;

  localparam int         RING_MAX   = 512;
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam logic [2:0] REG_SPARE0 = 3'd6;
  localparam logic [2:0] REG_SPARE1 = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors;
  int          waiting;

  // stimulus bookkeeping
  bit          loaded [RING_MAX];
  int          ring_used;
  int          idle_pct;
  int          sent_cnt;
  int          got_cnt;

  anharmonic_chain_time_step dut (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .cfg_we, .cfg_index, .cfg_data
  );

  anharmonic_chain_time_step_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .cfg_we, .cfg_index, .cfg_data, .errors, .waiting
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) if (rst_n && out_valid) got_cnt <= got_cnt + 1;

  // run limit
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [31:0] rand_q();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 32'h40000) - 32'h20000;
    return $urandom;
  endfunction

  // one command transfer, start stays high afterwards unless a random idle gap drops it
  task automatic send(logic [1:0] f, int site, logic [31:0] u, logic [31:0] v);
    in_item_t it;
    it.func = f;
    it.site_index = site[8:0];
    it.load_displacement = u;
    it.load_velocity = v;
    start   <= 1'b1;
    in_item <= it;
    do @(negedge clk); while (busy);
    @(posedge clk);
    sent_cnt++;
    if (f == FUNC_LOAD) loaded[site] = 1'b1;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (got_cnt != sent_cnt) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == REG_RING) begin
      ring_used = data[9:0];
      if (ring_used < 3) ring_used = 3;
      if (ring_used > RING_MAX) ring_used = RING_MAX;
    end
  endtask

  // one random command that never reads an unloaded site
  task automatic random_cmd();
    int pick, site;
    bit ring_ready;
    ring_ready = 1'b1;
    site = -1;
    for (int j = 0; j < ring_used; j++)
      if (!loaded[j]) begin
        ring_ready = 1'b0;
        if (site < 0) site = j;
      end
    pick = $urandom_range(0, 99);
    if (pick < 20 && ring_ready) begin
      send(FUNC_STEP, $urandom_range(0, RING_MAX - 1), $urandom, $urandom);
    end else if (pick < 50 || (pick < 20 && !ring_ready)) begin
      if (site < 0 || $urandom_range(0, 3) == 0)
        site = ($urandom_range(0, 4) == 0) ? $urandom_range(0, RING_MAX - 1)
                                           : $urandom_range(0, ring_used - 1);
      send(FUNC_LOAD, site, rand_q(), rand_q());
    end else if (pick < 94) begin
      do site = $urandom_range(0, RING_MAX - 1); while (!loaded[site]);
      send(FUNC_READ, site, $urandom, $urandom);
    end else begin
      send(FUNC_SPARE, $urandom_range(0, RING_MAX - 1), $urandom, $urandom);
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    sent_cnt  = 0;
    got_cnt   = 0;
    idle_pct  = 0;
    ring_used = 401;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: shortest ring, field extremes, every command
    cfg_write(REG_RING, 32'd0);
    cfg_we <= 1'b0;
    @(posedge clk);
    send(FUNC_LOAD, 0, 32'h7fff_ffff, 32'h8000_0000);
    send(FUNC_LOAD, 1, 32'h8000_0000, 32'h7fff_ffff);
    send(FUNC_LOAD, 2, 32'h0, 32'h0);
    send(FUNC_READ, 0, '0, '0);
    send(FUNC_READ, 1, '1, '1);
    send(FUNC_READ, 2, '0, '0);
    send(FUNC_SPARE, 511, 32'hffff_ffff, 32'hffff_ffff);
    send(FUNC_STEP, 0, '0, '0);
    send(FUNC_READ, 0, '0, '0);
    send(FUNC_READ, 1, '0, '0);
    send(FUNC_READ, 2, '0, '0);
    send(FUNC_LOAD, 511, $urandom, $urandom);
    send(FUNC_READ, 511, '0, '0);
    send(FUNC_LOAD, 0, 32'h0001_0000, 32'hffff_0000);
    send(FUNC_LOAD, 1, 32'h0002_8000, 32'h0000_4000);
    send(FUNC_LOAD, 2, 32'hfffe_0000, 32'h0);
    send(FUNC_STEP, 0, '0, '0);
    send(FUNC_READ, 1, '0, '0);
    send(FUNC_SPARE, 0, '0, '0);
    wait_idle();

    // random phases with their own settings and sender idling
    for (int seg = 0; seg < 3; seg++) begin
      idle_pct = (seg == 0) ? 24 : (seg == 1) ? 63 : 0;
      case (seg)
        0: begin
          cfg_write(REG_SPRING, $urandom_range(0, 4) << 16);
          cfg_write(REG_REST, 32'h0001_0000);
          cfg_write(REG_QUAD, $urandom_range(0, 32'h20000) - 32'h10000);
          cfg_write(REG_CUBIC, $urandom_range(0, 32'h8000));
          cfg_write(REG_DT, ($urandom & 32'h8000_0000) | $urandom_range(0, 4000));
          cfg_write(REG_RING, ($urandom & 32'hffff_fc00) | $urandom_range(3, 12));
        end
        1: begin
          cfg_write(REG_SPRING, 32'h7fff_ffff);
          cfg_write(REG_REST, 32'h8000_0000);
          cfg_write(REG_QUAD, 32'h8000_0000);
          cfg_write(REG_CUBIC, 32'h7fff_ffff);
          cfg_write(REG_DT, 32'hffff_ffff);
          cfg_write(REG_RING, 32'd2);
          cfg_write(REG_SPARE0, $urandom);
          cfg_write(REG_SPARE1, $urandom);
        end
        default: begin
          cfg_write(REG_SPRING, 32'h8000_0000);
          cfg_write(REG_REST, 32'h7fff_ffff);
          cfg_write(REG_QUAD, 32'h0);
          cfg_write(REG_CUBIC, 32'h8000_0000);
          cfg_write(REG_DT, 32'h0);
          cfg_write(REG_RING, $urandom_range(13, 24));
        end
      endcase
      cfg_we <= 1'b0;
      @(posedge clk);
      repeat (35) random_cmd();
      wait_idle();
    end

    // longer ring, upper bits of the length write dropped
    cfg_write(REG_SPRING, 32'h0001_0000);
    cfg_write(REG_REST, 32'h0001_0000);
    cfg_write(REG_QUAD, 32'h0000_8000);
    cfg_write(REG_CUBIC, 32'h0000_4000);
    cfg_write(REG_DT, 32'd412);
    cfg_write(REG_RING, 32'hffff_fc28);
    cfg_we <= 1'b0;
    @(posedge clk);
    for (int j = 0; j < ring_used; j++)
      if (!loaded[j]) send(FUNC_LOAD, j, rand_q(), rand_q());
    repeat (3) send(FUNC_STEP, 0, '0, '0);
    repeat (6) send(FUNC_READ, $urandom_range(0, ring_used - 1), '0, '0);
    wait_idle();
    repeat (20) @(posedge clk);

    if (errors == 0 && waiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- anharmonic_chain_time_step.f -----
+incdir+sv
sv/acts_pkg.sv
sv/acts_mul.sv
sv/anharmonic_chain_time_step.sv
tb/anharmonic_chain_time_step_checker.sv
tb/anharmonic_chain_time_step_tb.sv
